### src/mwc_pkg.sv
// Shared types and constants for the multiply-with-carry random number block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package mwc_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;

    localparam logic [HALF_W-1:0] Z_MULT  = 16'd36969;
    localparam logic [HALF_W-1:0] W_MULT  = 16'd18000;
    localparam logic [DATA_W-1:0] Z_RESET = 32'd60000;
    localparam logic [DATA_W-1:0] W_RESET = 32'd50000;

    localparam logic OP_RAW    = 1'b0;
    localparam logic OP_RANGED = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

endpackage

### src/mwc_gen.sv
// Generator state: the two 32-bit halves, advanced one after the other on a
// single shared multiply-add. Depends on mwc_pkg.
`timescale 1ns / 1ps

module mwc_gen
    import mwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  done,
    output word_t raw
);

    word_t              z_reg, z_next;
    word_t              w_reg, w_next;
    logic               busy_reg, busy_next;
    logic               sel_w_reg, sel_w_next;
    logic               done_reg, done_next;
    logic [HALF_W-1:0]  mult;
    word_t              src;
    word_t              prod;

    // Shared multiply-add: the z half first, then the w half.
    always_comb
    begin
        mult = sel_w_reg ? W_MULT : Z_MULT;
        src  = sel_w_reg ? w_reg : z_reg;
        prod = {{(DATA_W-HALF_W){1'b0}}, mult} * {{(DATA_W-HALF_W){1'b0}}, src[HALF_W-1:0]}
             + {{(DATA_W-HALF_W){1'b0}}, src[DATA_W-1:HALF_W]};
    end

    always_comb
    begin
        z_next     = z_reg;
        w_next     = w_reg;
        busy_next  = busy_reg;
        sel_w_next = sel_w_reg;
        done_next  = 1'b0;
        if (busy_reg)
        begin
            if (sel_w_reg)
            begin
                w_next     = prod;
                busy_next  = 1'b0;
                sel_w_next = 1'b0;
                done_next  = 1'b1;
            end
            else
            begin
                z_next     = prod;
                sel_w_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next  = 1'b1;
            sel_w_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg     <= Z_RESET;
            w_reg     <= W_RESET;
            busy_reg  <= 1'b0;
            sel_w_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            z_reg     <= z_next;
            w_reg     <= w_next;
            busy_reg  <= busy_next;
            sel_w_reg <= sel_w_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign raw  = {z_reg[HALF_W-1:0], {HALF_W{1'b0}}} + w_reg;

endmodule

### src/mwc_div.sv
// Restoring divider that produces the remainder one dividend bit per cycle.
// Depends on mwc_pkg.
`timescale 1ns / 1ps

module mwc_div
    import mwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    word_t              rem_reg, rem_next;
    word_t              quo_reg, quo_next;
    word_t              dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DATA_W:0]    trial;
    logic [DATA_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            // Keep the difference only when the divisor fit.
            rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### src/mwc_random_in_range.sv
// Multiply-with-carry random number source with optional range reduction.
// Each accepted item advances both 32-bit generator halves and returns one
// result item: the raw 32-bit value when op is 0, or the raw value reduced
// modulo (range_high - range_low + 1) and offset by range_low when op is 1,
// all modulo 2^32. Bounds that give a full 2^32 span skip the reduction and
// return raw + range_low. Inverted bounds are not an error; they simply form
// a large span. The block works on one item at a time and drops in_ready
// from acceptance until the result is loaded into the output register. A
// raw or full-span item passes through the two steps of the shared
// multiply-add that advances the halves and its done flag, then picking
// the path and loading the result. A ranged item also passes through the
// bit-serial restoring divider that forms the remainder, between picking
// the path and loading the result. The output register holds a finished
// result while out_ready is low, and the next item can be accepted in the
// meantime; that item then waits with its result until the register is
// free. Depends on mwc_pkg, mwc_gen and mwc_div.
`timescale 1ns / 1ps

module mwc_random_in_range
    import mwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  op,
    input  word_t range_low,
    input  word_t range_high,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_PICK,
        ST_DIV,
        ST_ADD
    } state_t;

    state_t state_reg;
    logic   op_reg;
    word_t  low_reg;
    word_t  span_reg;
    word_t  reduced_reg;
    logic   out_valid_reg;
    word_t  value_reg;

    logic   accept;
    logic   gen_done;
    word_t  raw;
    logic   div_start;
    logic   div_done;
    word_t  div_rem;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign div_start = (state_reg == ST_PICK) && (op_reg == OP_RANGED) && (span_reg != '0);

    mwc_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .done  (gen_done),
        .raw   (raw)
    );

    mwc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (raw),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
        end
        else
        begin
            // A finished result is loaded when the output register is empty
            // or is being emptied in this same cycle.
            if (state_reg == ST_ADD && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= reduced_reg + low_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_GEN;
                    end
                end
                ST_GEN:
                begin
                    if (gen_done)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    // A raw request or a full span uses the raw value as it is.
                    state_reg <= div_start ? ST_DIV : ST_ADD;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item fields and intermediate values; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            low_reg  <= (op == OP_RANGED) ? range_low : '0;
            span_reg <= range_high - range_low + 1'b1;
        end
        if (state_reg == ST_PICK)
        begin
            reduced_reg <= raw;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            reduced_reg <= div_rem;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

### src/mwc_checker.sv
// Port-level checks for mwc_random_in_range, attached by the bind below.
// Depends on mwc_pkg and the top level's ports.
`timescale 1ns / 1ps

module mwc_checker
    import mwc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  op,
    input word_t range_low,
    input word_t range_high,
    input logic  out_valid,
    input logic  out_ready,
    input word_t value
);

    // A waiting input item holds its fields until it is accepted.
    property p_in_hold;
        @(posedge clk) disable iff (!rst_n)
            in_valid && !in_ready |=> in_valid && $stable(op)
                && $stable(range_low) && $stable(range_high);
    endproperty
    a_in_hold: assert property (p_in_hold)
        else $error("input item changed while waiting");

    // A stalled result item holds its value.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            out_valid && !out_ready |=> out_valid && $stable(value);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result item changed while stalled");

    // An accepted item keeps the block busy while the generator advances its halves.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
            in_valid && in_ready |=> !in_ready ##1 !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("block ready again too soon after an item");

    // A result item cannot appear in the cycle right after acceptance.
    property p_no_early_result;
        @(posedge clk) disable iff (!rst_n)
            in_valid && in_ready && !out_valid |=> !out_valid;
    endproperty
    a_no_early_result: assert property (p_no_early_result)
        else $error("result item appeared too early");

    // After reset the output is empty.
    property p_reset_empty;
        @(posedge clk) disable iff (!rst_n)
            $rose(rst_n) |-> !out_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result item valid right after reset");

endmodule

bind mwc_random_in_range mwc_checker u_mwc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value)
);
